/* rtl/rtp_receive_sequence_jitter_tracker_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the RTP receive tracker.
// ----------------------------------------------------------------------------
`ifndef RTP_RECEIVE_SEQUENCE_JITTER_TRACKER_CORE_ASSERT_SVH
`define RTP_RECEIVE_SEQUENCE_JITTER_TRACKER_CORE_ASSERT_SVH

// The expression must never hold outside reset.
`define RTPRX_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define RTPRX_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/rtprx_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtprx_pkg
// Types and fixed constants shared by the RTP receive tracker modules.
// ----------------------------------------------------------------------------
package rtprx_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_ACCEPTED   = 2'd0,
    STATUS_BAD_HEADER = 2'd1,
    STATUS_FOREIGN    = 2'd2,
    STATUS_SEQ_DROP   = 2'd3
  } status_t;

  // Configuration register indexes.
  localparam logic [7:0] REG_DROPOUT_LIMIT  = 8'd0;
  localparam logic [7:0] REG_MISORDER_LIMIT = 8'd1;
  localparam logic [7:0] REG_CLOCK_RATE     = 8'd2;

  localparam int LIMIT_W      = 15;
  localparam int CLOCK_RATE_W = 20;

  localparam logic [LIMIT_W-1:0]      DROPOUT_RESET  = 15'd3000;
  localparam logic [LIMIT_W-1:0]      MISORDER_RESET = 15'd100;
  localparam logic [CLOCK_RATE_W-1:0] CLOCK_RESET    = 20'd90000;

  // Header constants.
  localparam logic [16:0] MIN_HEADER_LEN = 17'd12;
  localparam logic [1:0]  RTP_VERSION    = 2'd2;
  localparam int          PAD_FLAG_BIT   = 5;

  // Running average rounding term (1/16 gain).
  localparam logic [35:0] AVG_ROUND = 36'd8;

  // Divider: 64-bit dividend, a few quotient bits per pipeline stage.
  localparam int DIV_BITS   = 64;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = DIV_BITS / DIV_STEP;

  // Queue depths.
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 32;

  typedef struct packed {
    logic [15:0] packet_length;
    logic [7:0]  first_byte;
    logic [7:0]  pad_count;
    logic [15:0] sequence_req;
    logic [31:0] media_time;
    logic [31:0] source_id;
    logic [62:0] arrival_time;
  } packet_t;

  typedef struct packed {
    status_t            status;
    logic               resynced;
    logic signed [31:0] packet_jitter;
    logic [31:0]        mean_jitter;
    logic [15:0]        trimmed_length;
  } result_t;

  // Fields that ride along the jitter pipeline.
  typedef struct packed {
    status_t            status;
    logic               resynced;
    logic [15:0]        trimmed_length;
    logic               do_jitter;
    logic signed [32:0] media_delta;
  } side_t;

  // Classified word passed from the front to the back.
  typedef struct packed {
    side_t       side;
    logic [63:0] arrival_delta;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/rtprx_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtprx_fifo
// Small register-based first-in first-out queue with a count.
// ----------------------------------------------------------------------------
module rtprx_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr_ok;
  logic             rd_ok;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign wr_ok   = wr_en & ~full;
  assign rd_ok   = rd_en & ~empty;
  assign rd_data = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_ok) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_ok) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(wr_ok) - CNT_W'(rd_ok);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/rtprx_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtprx_front
// Checks the header and the source, validates the sequence number and
// produces one classified word per accepted packet.
// ----------------------------------------------------------------------------
module rtprx_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  rtprx_pkg::packet_t                  packet,
  input  logic [rtprx_pkg::LIMIT_W-1:0]       dropout_limit,
  input  logic [rtprx_pkg::LIMIT_W-1:0]       misorder_limit,
  output rtprx_pkg::cmd_t                     cmd
);
  import rtprx_pkg::*;

  logic        source_known;
  logic [31:0] locked_source;
  logic [15:0] highest_next_seq;
  logic [15:0] suspect_seq;
  logic [62:0] previous_arrival;
  logic [31:0] previous_media_time;

  logic        pad_flag;
  logic        hdr_bad;
  logic        foreign;
  logic        pkt_ok;
  logic [15:0] trimmed;
  logic [15:0] seq_base;
  logic [15:0] suspect_base;
  logic [15:0] seq_diff;
  logic [15:0] back_mag;
  logic        seq_bad;
  logic        seq_resync;
  logic [15:0] seq_plus1;

  // Header checks and padding removal.
  always_comb begin
    pad_flag = packet.first_byte[PAD_FLAG_BIT];
    hdr_bad  = ({1'b0, packet.packet_length} < MIN_HEADER_LEN) ||
               (packet.first_byte[7:6] != RTP_VERSION) ||
               (pad_flag && ({1'b0, packet.packet_length} <
                             MIN_HEADER_LEN + {9'd0, packet.pad_count}));
    trimmed  = (!hdr_bad && pad_flag) ?
               packet.packet_length - {8'd0, packet.pad_count} : packet.packet_length;
    foreign  = !hdr_bad && source_known && (packet.source_id != locked_source);
    pkt_ok   = !hdr_bad && !foreign;
  end

  // Sequence validation; a first packet starts from its own number.
  always_comb begin
    seq_base     = source_known ? highest_next_seq : packet.sequence_req;
    suspect_base = source_known ? suspect_seq : packet.sequence_req;
    seq_diff     = packet.sequence_req - seq_base;
    back_mag     = 16'd0 - seq_diff;
    seq_plus1    = packet.sequence_req + 16'd1;
    if (!seq_diff[15] && (seq_diff != 16'd0)) begin
      seq_bad = seq_diff[14:0] > dropout_limit;
    end else begin
      seq_bad = back_mag > {1'b0, misorder_limit};
    end
    seq_resync = seq_bad && (packet.sequence_req == suspect_base);
  end

  // Classified word for the back end.
  always_comb begin
    cmd.side.trimmed_length = trimmed;
    cmd.side.resynced       = pkt_ok && seq_resync;
    cmd.side.do_jitter      = pkt_ok && source_known &&
                              (packet.media_time != previous_media_time);
    cmd.side.media_delta    = $signed({1'b0, packet.media_time}) -
                              $signed({1'b0, previous_media_time});
    cmd.arrival_delta       = {1'b0, packet.arrival_time} - {1'b0, previous_arrival};
    if (hdr_bad) begin
      cmd.side.status = STATUS_BAD_HEADER;
    end else if (foreign) begin
      cmd.side.status = STATUS_FOREIGN;
    end else if (seq_bad && !seq_resync) begin
      cmd.side.status = STATUS_SEQ_DROP;
    end else begin
      cmd.side.status = STATUS_ACCEPTED;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_known        <= 1'b0;
      locked_source       <= '0;
      highest_next_seq    <= '0;
      suspect_seq         <= '0;
      previous_arrival    <= '0;
      previous_media_time <= '0;
    end else if (accept && pkt_ok) begin
      source_known        <= 1'b1;
      previous_arrival    <= packet.arrival_time;
      previous_media_time <= packet.media_time;
      if (!source_known) begin
        locked_source <= packet.source_id;
      end
      if (seq_bad) begin
        suspect_seq <= seq_plus1;
        if (seq_resync) begin
          highest_next_seq <= seq_plus1;
        end
      end else begin
        if (!seq_diff[15]) begin
          highest_next_seq <= seq_plus1;
        end
        suspect_seq <= suspect_base;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/rtprx_jitter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtprx_jitter
// Fixed-latency pipeline: scales the arrival difference by the clock rate,
// divides by the tick rate, forms the transit difference and updates the
// running jitter average.
// ----------------------------------------------------------------------------
module rtprx_jitter #(
  parameter int TICKS_PER_SECOND = 1000000
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  rtprx_pkg::cmd_t                       in_cmd,
  input  logic [rtprx_pkg::CLOCK_RATE_W-1:0]    clock_rate,
  output logic                                  out_valid,
  output rtprx_pkg::result_t                    out_result
);
  import rtprx_pkg::*;

  localparam int DW = $clog2(TICKS_PER_SECOND + 1);
  localparam logic [DW:0] DIVISOR = (DW + 1)'(TICKS_PER_SECOND);

  // Multiply stage.
  logic        v1;
  side_t       side1;
  logic [51:0] prod_lo;
  logic [31:0] prod_hi;

  // Sum stage.
  logic        v2;
  side_t       side2;
  logic [63:0] prod2;

  // Divider stages; index 0 is the magnitude stage.
  logic          dv    [DIV_STAGES+1];
  side_t         dside [DIV_STAGES+1];
  logic          dneg  [DIV_STAGES+1];
  logic [DW-1:0] drem  [DIV_STAGES+1];
  logic [63:0]   dwork [DIV_STAGES+1];

  // Post-divide stages.
  logic        v5;
  side_t       side5;
  logic [63:0] quot5;
  logic        v6;
  side_t       side6;
  logic [63:0] diff6;
  logic        v7;
  side_t       side7;
  logic [31:0] pj7;
  logic [35:0] mag7;

  logic [31:0] average_jitter;
  logic [31:0] average_jitter_next;
  logic [35:0] avg_step;

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      dv[0] <= 1'b0;
      v5    <= 1'b0;
      v6    <= 1'b0;
      v7    <= 1'b0;
    end else begin
      v1    <= in_valid;
      v2    <= v1;
      dv[0] <= v2;
      v5    <= dv[DIV_STAGES];
      v6    <= v5;
      v7    <= v6;
    end
  end

  // Scale by the clock rate, modulo 2^64, as two partial products.
  always_ff @(posedge clk) begin
    side1   <= in_cmd.side;
    prod_lo <= in_cmd.arrival_delta[31:0] * clock_rate;
    prod_hi <= 32'(in_cmd.arrival_delta[63:32] * clock_rate);
  end

  always_ff @(posedge clk) begin
    side2 <= side1;
    prod2 <= {12'd0, prod_lo} + {prod_hi, 32'd0};
  end

  // Sign and magnitude ahead of the divider.
  always_ff @(posedge clk) begin
    dside[0] <= side2;
    dneg[0]  <= prod2[63];
    drem[0]  <= '0;
    dwork[0] <= prod2[63] ? 64'd0 - prod2 : prod2;
  end

  // Restoring division, a few quotient bits per stage.
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [DW-1:0] rem_c;
    logic [63:0]   work_c;
    logic [DW:0]   trial;
    logic [DW:0]   trial_sub;

    always_comb begin
      rem_c     = drem[k];
      work_c    = dwork[k];
      trial     = '0;
      trial_sub = '0;
      for (int b = 0; b < DIV_STEP; b++) begin
        trial     = {rem_c, work_c[63]};
        trial_sub = trial - DIVISOR;
        work_c    = {work_c[62:0], 1'b0};
        if (trial >= DIVISOR) begin
          rem_c     = trial_sub[DW-1:0];
          work_c[0] = 1'b1;
        end else begin
          rem_c = trial[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      dside[k+1] <= dside[k];
      dneg[k+1]  <= dneg[k];
      drem[k+1]  <= rem_c;
      dwork[k+1] <= work_c;
    end
  end

  // Restore the sign (truncation toward zero).
  always_ff @(posedge clk) begin
    side5 <= dside[DIV_STAGES];
    quot5 <= dneg[DIV_STAGES] ? 64'd0 - dwork[DIV_STAGES] : dwork[DIV_STAGES];
  end

  // Subtract the timestamp difference.
  always_ff @(posedge clk) begin
    side6 <= side5;
    diff6 <= quot5 - {{31{side5.media_delta[32]}}, side5.media_delta};
  end

  // Magnitude; only the low bits reach the average.
  always_ff @(posedge clk) begin
    side7 <= side6;
    pj7   <= diff6[31:0];
    mag7  <= diff6[63] ? 36'd0 - diff6[35:0] : diff6[35:0];
  end

  // Running average with 1/16 gain.
  always_comb begin
    avg_step            = mag7 - {4'd0, average_jitter} + AVG_ROUND;
    average_jitter_next = average_jitter;
    if (v7 && side7.do_jitter) begin
      average_jitter_next = average_jitter + avg_step[35:4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      average_jitter <= '0;
    end else begin
      average_jitter <= average_jitter_next;
    end
  end

  // Result word.
  always_comb begin
    out_valid                 = v7;
    out_result.status         = side7.status;
    out_result.resynced       = side7.resynced;
    out_result.packet_jitter  = side7.do_jitter ? pj7 : 32'sd0;
    out_result.mean_jitter    = average_jitter_next;
    out_result.trimmed_length = side7.trimmed_length;
  end

endmodule
`default_nettype wire

/* rtl/rtp_receive_sequence_jitter_tracker_core.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "rtp_receive_sequence_jitter_tracker_core_assert.svh"
// ----------------------------------------------------------------------------
// rtp_receive_sequence_jitter_tracker_core
// RTP receive checker: header and source checks, sequence validation and
// interarrival jitter tracking, one result word per packet word.
// ----------------------------------------------------------------------------
// Usage:
//   Packet words enter on push/full like a queue write port; a word is taken
//   at an edge where push is high and full is low. Result words leave on
//   empty/pop; the oldest result sits on the result port while empty is low.
//   Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data
//   (cfg_ready is always high); the user must write them only while no
//   packet is in flight; the block itself does not enforce this.
//   Most of the path from a taken packet to its result is the pipelined
//   64-bit divider by the tick rate.
//   Throughput: one packet word per cycle, sustained while full stays low.
//   A stalled result side fills a 32-word result queue; issue into the
//   pipeline stops when the queue could not hold what is in flight, then the
//   4-word queue behind the front fills and full rises.
//   Reset clears the locked source, sequence state, jitter average and the
//   queues, and restores the register defaults.
// ----------------------------------------------------------------------------
module rtp_receive_sequence_jitter_tracker_core #(
  parameter int TICKS_PER_SECOND = 1000000
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  rtprx_pkg::packet_t   packet,
  output logic                 empty,
  input  logic                 pop,
  output rtprx_pkg::result_t   result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import rtprx_pkg::*;

  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  logic [LIMIT_W-1:0]      dropout_limit;
  logic [LIMIT_W-1:0]      misorder_limit;
  logic [CLOCK_RATE_W-1:0] clock_rate;

  logic      accept;
  cmd_t      front_cmd;
  cmd_t      mid_cmd;
  logic      mid_empty;
  logic      issue;
  logic      res_valid;
  result_t   res_word;
  logic      out_full;
  logic      out_pop;
  logic [CNT_W-1:0] inflight;

  assign cfg_ready = 1'b1;
  assign accept    = push & ~full;
  assign out_pop   = pop & ~empty;
  assign issue     = ~mid_empty & (inflight < CNT_W'(OUT_DEPTH));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dropout_limit  <= DROPOUT_RESET;
      misorder_limit <= MISORDER_RESET;
      clock_rate     <= CLOCK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DROPOUT_LIMIT:  dropout_limit  <= cfg_data[LIMIT_W-1:0];
        REG_MISORDER_LIMIT: misorder_limit <= cfg_data[LIMIT_W-1:0];
        REG_CLOCK_RATE:     clock_rate     <= cfg_data[CLOCK_RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: classification and stream state.
  rtprx_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .packet         (packet),
    .dropout_limit  (dropout_limit),
    .misorder_limit (misorder_limit),
    .cmd            (front_cmd)
  );

  // Queue between front and back.
  rtprx_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (front_cmd),
    .rd_en   (issue),
    .rd_data (mid_cmd),
    .full    (full),
    .empty   (mid_empty)
  );

  // Back: jitter arithmetic.
  rtprx_jitter #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_jitter (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (issue),
    .in_cmd     (mid_cmd),
    .clock_rate (clock_rate),
    .out_valid  (res_valid),
    .out_result (res_word)
  );

  // Result queue.
  rtprx_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res_word),
    .rd_en   (out_pop),
    .rd_data (result),
    .full    (out_full),
    .empty   (empty)
  );

  // Words issued to the back and not yet popped; keeps room in the result queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNT_W'(issue) - CNT_W'(out_pop);
    end
  end

  `RTPRX_ASSERT_NEVER(a_credit_bound, clk, rst, inflight > CNT_W'(OUT_DEPTH), "inflight count above result queue depth")
  `RTPRX_ASSERT_NEVER(a_no_overflow, clk, rst, res_valid && out_full, "result written into a full queue")
  `RTPRX_ASSERT_IMPLIES(a_idle_empty, clk, rst, inflight == '0, empty, "result queue holds words with nothing in flight")

endmodule
`default_nettype wire
